FILE: design/grm_pkg.sv
package grm_pkg;

    localparam int MAP_SIZE       = 16;
    localparam int STEPS_PER_TILE = 10;
    localparam int CELL_SPAN      = 16384 * STEPS_PER_TILE;
    localparam int POS_W          = $clog2(CELL_SPAN);
    localparam int N_W            = $clog2(16 * STEPS_PER_TILE + 1);
    localparam int CELL_W         = 6;
    localparam int MUL_A_W        = 15;
    localparam int MUL_B_W        = 10;
    localparam int DIV_N_W        = MUL_A_W + MUL_B_W;
    localparam int DIV_D_W        = 12;
    localparam int DIV_CNT_W      = $clog2(DIV_N_W);

    localparam logic signed [POS_W+1:0] SPAN_WIDE = (POS_W+2)'(CELL_SPAN);
    localparam logic [N_W-1:0]          TWO_S     = N_W'(2 * STEPS_PER_TILE);

    typedef enum logic [2:0] {
        REG_WALL0  = 3'd0,
        REG_WALL1  = 3'd1,
        REG_WALL2  = 3'd2,
        REG_WALL3  = 3'd3,
        REG_FOV    = 3'd4,
        REG_WIDTH  = 3'd5,
        REG_HEIGHT = 3'd6,
        REG_DEPTH  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0]         pos;
        logic signed [CELL_W-1:0] tile;
    } axis_t;

    function automatic logic [14:0] quarter_sine(input logic [5:0] idx);
        logic [14:0] v;
        case (idx)
            6'd0:  v = 15'd0;
            6'd1:  v = 15'd804;
            6'd2:  v = 15'd1606;
            6'd3:  v = 15'd2404;
            6'd4:  v = 15'd3196;
            6'd5:  v = 15'd3981;
            6'd6:  v = 15'd4756;
            6'd7:  v = 15'd5520;
            6'd8:  v = 15'd6270;
            6'd9:  v = 15'd7005;
            6'd10: v = 15'd7723;
            6'd11: v = 15'd8423;
            6'd12: v = 15'd9102;
            6'd13: v = 15'd9760;
            6'd14: v = 15'd10394;
            6'd15: v = 15'd11003;
            6'd16: v = 15'd11585;
            6'd17: v = 15'd12140;
            6'd18: v = 15'd12665;
            6'd19: v = 15'd13160;
            6'd20: v = 15'd13623;
            6'd21: v = 15'd14053;
            6'd22: v = 15'd14449;
            6'd23: v = 15'd14811;
            6'd24: v = 15'd15137;
            6'd25: v = 15'd15426;
            6'd26: v = 15'd15679;
            6'd27: v = 15'd15893;
            6'd28: v = 15'd16069;
            6'd29: v = 15'd16207;
            6'd30: v = 15'd16305;
            6'd31: v = 15'd16364;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    // one march step along one axis, tile index moves by at most one
    function automatic axis_t axis_step(input axis_t cur, input logic signed [15:0] dir);
        logic signed [POS_W+1:0] sum;
        axis_t                   nxt;
        sum = $signed({2'b00, cur.pos}) + (POS_W+2)'(dir);
        nxt = cur;
        if (sum < 0)
        begin
            nxt.pos  = POS_W'(sum + SPAN_WIDE);
            nxt.tile = cur.tile - CELL_W'(1);
        end
        else if (sum >= SPAN_WIDE)
        begin
            nxt.pos  = POS_W'(sum - SPAN_WIDE);
            nxt.tile = cur.tile + CELL_W'(1);
        end
        else
        begin
            nxt.pos = POS_W'(sum);
        end
        return nxt;
    endfunction

endpackage

FILE: design/grid_ray_march_column_unit.sv
// Casts the ray of one screen column through a 16x16 wall bitmap.
// Command port: an item (player_x, player_y, heading, column_index) is taken
// at a clock edge with start high and busy low. busy stays high until the
// result is out. The result is shown for one cycle with done high; the
// receiver has no way to hold it, so it must take it in that cycle.
// Configuration: cfg_write, cfg_index, cfg_data write one register per edge,
// indexes 0..3 wall rows, 4 field of view, 5 screen width, 6 screen height,
// 7 max depth. Write only while busy is low.
// Sequence: busy covers the angle division, sine and cosine, a march of n steps
// (1 to 10 * max_depth) and the ceiling division, and done follows; with start
// held, the next item is taken once busy falls. The two 25-step divisions (ray
// angle, ceiling row) run on one shared restoring divider, the multiplications on
// one shared multiplier, and the march does one step per cycle.
// Reset: registers return to their defaults (empty map, 8192 view angle,
// 320 x 240 screen, depth 16), the sequencer goes idle and no result is
// pending.
module grid_ray_march_column_unit
    import grm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        player_x,
    input  logic [15:0]        player_y,
    input  logic [15:0]        heading,
    input  logic [9:0]         column_index,
    output logic               done,
    output logic [9:0]         column_out,
    output logic [7:0]         distance_tenths,
    output logic               wall_visible,
    output logic signed [10:0] ceiling_row,
    output logic [10:0]        floor_row,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANG_MUL,
        S_ANG_LOAD,
        S_ANG_DIV,
        S_RAY,
        S_SIN_MUL,
        S_COS_MUL,
        S_COS_FIN,
        S_MARCH,
        S_CEIL_MUL,
        S_CEIL_LOAD,
        S_CEIL_DIV,
        S_OUT
    } state_t;

    logic [63:0] wall0_reg, wall1_reg, wall2_reg, wall3_reg;
    logic [14:0] fov_reg;
    logic [10:0] width_reg;
    logic [9:0]  height_reg;
    logic [4:0]  depth_reg;

    state_t state_reg, state_next;
    logic [15:0] px_reg, px_next, py_reg, py_next, hd_reg, hd_next;
    logic [9:0]  col_reg, col_next;
    logic [DIV_N_W-1:0] prod_reg, prod_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next, dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0] ray_reg, ray_next;
    logic [14:0] sin_base_reg, sin_base_next;
    logic        sin_sat_reg, sin_sat_next, sin_neg_reg, sin_neg_next;
    logic signed [15:0] ex_reg, ex_next, ey_reg, ey_next;
    axis_t       ax_reg, ax_next, ay_reg, ay_next;
    logic [N_W-1:0] n_reg, n_next;
    logic        cneg_reg, cneg_next;
    logic        done_reg, done_next;
    logic [9:0]  col_out_reg, col_out_next;
    logic [7:0]  dist_reg, dist_next;
    logic        vis_reg, vis_next;
    logic signed [10:0] ceil_reg, ceil_next;
    logic [10:0] floor_reg, floor_next;

    logic [10:0]    width_eff;
    logic [4:0]     depth_eff;
    logic [N_W-1:0] limit;
    logic [255:0]   wall_map;

    logic [15:0] angle;
    logic [14:0] tq;
    logic [5:0]  tidx;
    logic [14:0] tab_lo, tab_hi, tab_diff;
    logic [14:0] trig_mag;
    logic signed [15:0] trig_val;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    logic [DIV_D_W:0]   div_shift;
    logic               div_ge;

    axis_t ax_step, ay_step;
    logic  leave_map, hit_wall;
    logic [N_W-1:0] c_mag;
    logic [9:0]     c_sat;
    logic [15:0]    n_wide;

    assign width_eff = (width_reg == 11'd0) ? 11'd1 : width_reg;
    assign depth_eff = (depth_reg == 5'd0) ? 5'd1 : ((depth_reg > 5'd16) ? 5'd16 : depth_reg);
    assign limit     = N_W'(depth_eff * STEPS_PER_TILE);
    assign wall_map  = {wall3_reg, wall2_reg, wall1_reg, wall0_reg};

    // sine table lookup, cosine is sine a quarter turn on
    assign angle    = (state_reg == S_COS_MUL) ? ray_reg + 16'd16384 : ray_reg;
    assign tq       = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    assign tidx     = tq[14:9];
    assign tab_lo   = quarter_sine(tidx);
    assign tab_hi   = quarter_sine(tidx + 6'd1);
    assign tab_diff = tab_hi - tab_lo;
    assign trig_mag = sin_sat_reg ? 15'd16384 : sin_base_reg + 15'(prod_reg >> 9);
    assign trig_val = sin_neg_reg ? -$signed({1'b0, trig_mag}) : $signed({1'b0, trig_mag});

    assign div_shift = {rem_reg, quo_reg[DIV_N_W-1]};
    assign div_ge    = div_shift >= {1'b0, dvs_reg};

    assign ax_step   = axis_step(ax_reg, ex_reg);
    assign ay_step   = axis_step(ay_reg, ey_reg);
    assign leave_map = ax_step.tile[CELL_W-1] || (ax_step.tile >= $signed(CELL_W'(MAP_SIZE)))
                    || ay_step.tile[CELL_W-1] || (ay_step.tile >= $signed(CELL_W'(MAP_SIZE)));
    assign hit_wall  = wall_map[{ay_step.tile[3:0], ax_step.tile[3:0]}];

    assign c_mag  = (n_reg < TWO_S) ? TWO_S - n_reg : n_reg - TWO_S;
    assign c_sat  = (quo_reg > DIV_N_W'(1023)) ? 10'd1023 : quo_reg[9:0];
    assign n_wide = 16'(n_reg);

    always_comb
    begin
        case (state_reg)
            S_ANG_MUL:
            begin
                mul_a = fov_reg;
                mul_b = col_reg;
            end
            S_SIN_MUL, S_COS_MUL:
            begin
                mul_a = tab_diff;
                mul_b = {1'b0, tq[8:0]};
            end
            S_CEIL_MUL:
            begin
                mul_a = MUL_A_W'(height_reg);
                mul_b = MUL_B_W'(c_mag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        hd_next       = hd_reg;
        col_next      = col_reg;
        prod_next     = DIV_N_W'(mul_a * mul_b);
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        ray_next      = ray_reg;
        sin_base_next = sin_base_reg;
        sin_sat_next  = sin_sat_reg;
        sin_neg_next  = sin_neg_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        n_next        = n_reg;
        cneg_next     = cneg_reg;
        done_next     = 1'b0;
        col_out_next  = col_out_reg;
        dist_next     = dist_reg;
        vis_next      = vis_reg;
        ceil_next     = ceil_reg;
        floor_next    = floor_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = player_x;
                    py_next    = player_y;
                    hd_next    = heading;
                    col_next   = column_index;
                    state_next = S_ANG_MUL;
                end
            end
            S_ANG_MUL:
            begin
                state_next = S_ANG_LOAD;
            end
            S_ANG_LOAD:
            begin
                quo_next   = prod_reg;
                rem_next   = '0;
                dvs_next   = DIV_D_W'(width_eff);
                cnt_next   = '0;
                state_next = S_ANG_DIV;
            end
            S_ANG_DIV, S_CEIL_DIV:
            begin
                rem_next = div_ge ? DIV_D_W'(div_shift - {1'b0, dvs_reg})
                                  : div_shift[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], div_ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                begin
                    state_next = (state_reg == S_ANG_DIV) ? S_RAY : S_OUT;
                end
            end
            S_RAY:
            begin
                ray_next   = hd_reg - 16'(fov_reg >> 1) + quo_reg[15:0];
                state_next = S_SIN_MUL;
            end
            S_SIN_MUL:
            begin
                sin_base_next = tab_lo;
                sin_sat_next  = tidx[5];
                sin_neg_next  = angle[15];
                state_next    = S_COS_MUL;
            end
            S_COS_MUL:
            begin
                ex_next       = trig_val;
                sin_base_next = tab_lo;
                sin_sat_next  = tidx[5];
                sin_neg_next  = angle[15];
                state_next    = S_COS_FIN;
            end
            S_COS_FIN:
            begin
                ey_next      = trig_val;
                ax_next.pos  = POS_W'(px_reg[11:0] * (4 * STEPS_PER_TILE));
                ax_next.tile = CELL_W'(px_reg[15:12]);
                ay_next.pos  = POS_W'(py_reg[11:0] * (4 * STEPS_PER_TILE));
                ay_next.tile = CELL_W'(py_reg[15:12]);
                n_next       = N_W'(1);
                state_next   = S_MARCH;
            end
            S_MARCH:
            begin
                ax_next = ax_step;
                ay_next = ay_step;
                if (leave_map)
                begin
                    n_next     = limit;
                    state_next = S_CEIL_MUL;
                end
                else if (hit_wall || n_reg == limit)
                begin
                    state_next = S_CEIL_MUL;
                end
                else
                begin
                    n_next = n_reg + N_W'(1);
                end
            end
            S_CEIL_MUL:
            begin
                cneg_next  = n_reg < TWO_S;
                state_next = S_CEIL_LOAD;
            end
            S_CEIL_LOAD:
            begin
                quo_next   = prod_reg;
                rem_next   = '0;
                dvs_next   = DIV_D_W'({n_reg, 1'b0});
                cnt_next   = '0;
                state_next = S_CEIL_DIV;
            end
            S_OUT:
            begin
                done_next    = 1'b1;
                col_out_next = col_reg;
                dist_next    = (n_wide > 16'd255) ? 8'd255 : n_wide[7:0];
                vis_next     = n_reg < limit;
                ceil_next    = cneg_reg ? -$signed({1'b0, c_sat}) : $signed({1'b0, c_sat});
                floor_next   = {1'b0, height_reg}
                             - (cneg_reg ? 11'(-$signed({1'b0, c_sat})) : {1'b0, c_sat});
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            col_out_reg <= '0;
            dist_reg    <= '0;
            vis_reg     <= 1'b0;
            ceil_reg    <= '0;
            floor_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            col_out_reg <= col_out_next;
            dist_reg    <= dist_next;
            vis_reg     <= vis_next;
            ceil_reg    <= ceil_next;
            floor_reg   <= floor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        hd_reg       <= hd_next;
        col_reg      <= col_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        cnt_reg      <= cnt_next;
        ray_reg      <= ray_next;
        sin_base_reg <= sin_base_next;
        sin_sat_reg  <= sin_sat_next;
        sin_neg_reg  <= sin_neg_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        n_reg        <= n_next;
        cneg_reg     <= cneg_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall0_reg  <= '0;
            wall1_reg  <= '0;
            wall2_reg  <= '0;
            wall3_reg  <= '0;
            fov_reg    <= 15'd8192;
            width_reg  <= 11'd320;
            height_reg <= 10'd240;
            depth_reg  <= 5'd16;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WALL0:  wall0_reg  <= cfg_data;
                REG_WALL1:  wall1_reg  <= cfg_data;
                REG_WALL2:  wall2_reg  <= cfg_data;
                REG_WALL3:  wall3_reg  <= cfg_data;
                REG_FOV:    fov_reg    <= cfg_data[14:0];
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data[9:0];
                REG_DEPTH:  depth_reg  <= cfg_data[4:0];
                default:    depth_reg  <= depth_reg;
            endcase
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign column_out      = col_out_reg;
    assign distance_tenths = dist_reg;
    assign wall_visible    = vis_reg;
    assign ceiling_row     = ceil_reg;
    assign floor_row       = floor_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is still running");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_march_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARCH) |-> (n_reg >= N_W'(1) && n_reg <= limit))
        else $error("march step count out of range");

    a_visible_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (done && wall_visible) |-> (16'(distance_tenths) < 16'(limit)))
        else $error("visible wall at or beyond max depth");

endmodule
